// ----- sv/abd_pkg.sv -----
`timescale 1ns / 1ps

package abd_pkg;

    localparam int BANK_W    = 3;
    localparam int WORD_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PRESS_TIME      = 2'd0;
    localparam cfg_idx_t CFG_RELEASE_TIME    = 2'd1;
    localparam cfg_idx_t CFG_DEBOUNCE_ENABLE = 2'd2;

    localparam logic [HOLD_W-1:0] PRESS_TIME_RST   = 16'd10;
    localparam logic [HOLD_W-1:0] RELEASE_TIME_RST = 16'd10;
    localparam logic              ENABLE_RST       = 1'b1;

endpackage

// ----- sv/asymmetric_bit_debouncer_core.sv -----
`timescale 1ns / 1ps

// Input accept registers the stamp row read; the update is then registered as the result.
// Throughput: one request per cycle while m_ready does not stall; set by the single registered
// row read of the per-bank stamp memories, with a bypass when back-to-back requests hit one bank.
// Reset (aresetn low, synchronous): hold times back to 10 ms, debouncing enabled,
// previous and debounced words zero, stamp rows marked empty (read as zero), no
// request in flight. No clearing pass: the block is ready the cycle after reset.
module asymmetric_bit_debouncer_core #(
    parameter int BANKS         = 5,
    parameter int BITS_PER_BANK = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abd_pkg::HOLD_W-1:0]        cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [abd_pkg::BANK_W-1:0]        s_bank,
    input  logic [abd_pkg::WORD_W-1:0]        s_raw_word,
    input  logic [abd_pkg::STAMP_W-1:0]       s_now_ms,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [abd_pkg::BANK_W-1:0]        m_out_bank,
    output logic [abd_pkg::WORD_W-1:0]        m_clean_word
);

    localparam int BANK_AW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int SW      = abd_pkg::STAMP_W;

    typedef logic [BITS_PER_BANK-1:0][SW-1:0] row_t;
    typedef logic [BITS_PER_BANK-1:0]         lane_t;

    // configuration
    logic [abd_pkg::HOLD_W-1:0] press_time_reg;
    logic [abd_pkg::HOLD_W-1:0] release_time_reg;
    logic                       enable_reg;

    // per-bank state
    lane_t prev_raw_reg    [BANKS];
    lane_t clean_store_reg [BANKS];
    logic  row_valid_reg   [BANKS];
    row_t  press_mem       [BANKS];
    row_t  release_mem     [BANKS];

    // stage 1
    logic                        s1_valid_reg;
    logic [abd_pkg::BANK_W-1:0]  s1_bank_reg;
    logic [BANK_AW-1:0]          s1_idx_reg;
    logic                        s1_inrange_reg;
    lane_t                       s1_raw_reg;
    logic [SW-1:0]               s1_now_reg;
    row_t                        press_rd_reg;
    row_t                        release_rd_reg;

    // result
    logic                        m_valid_reg;
    logic [abd_pkg::BANK_W-1:0]  m_bank_reg;
    logic [abd_pkg::WORD_W-1:0]  m_word_reg;

    logic                        s_accept;
    logic                        s_inrange;
    logic [BANK_AW-1:0]          s_idx;
    logic                        s1_adv;
    logic                        commit;
    logic                        state_we;
    logic                        mem_we;
    logic                        fwd;

    lane_t                       prev_word;
    lane_t                       clean_old;
    lane_t                       clean_new;
    row_t                        press_wr;
    row_t                        release_wr;
    logic [SW-1:0]               press_diff   [BITS_PER_BANK];
    logic [SW-1:0]               release_diff [BITS_PER_BANK];
    logic [abd_pkg::WORD_W-1:0]  result_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_time_reg   <= abd_pkg::PRESS_TIME_RST;
            release_time_reg <= abd_pkg::RELEASE_TIME_RST;
            enable_reg       <= abd_pkg::ENABLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                abd_pkg::CFG_PRESS_TIME:      press_time_reg   <= cfg_data;
                abd_pkg::CFG_RELEASE_TIME:    release_time_reg <= cfg_data;
                abd_pkg::CFG_DEBOUNCE_ENABLE: enable_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_adv   = !m_valid_reg || m_ready;
    assign commit   = s1_valid_reg && s1_adv;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    assign s_inrange = (32'(s_bank) < 32'(BANKS));
    assign s_idx     = s_inrange ? BANK_AW'(s_bank) : '0;

    assign state_we = commit && s1_inrange_reg;
    assign mem_we   = state_we && enable_reg;
    // bypass the row being written back when the next request hits the same bank
    assign fwd      = mem_we && (s1_idx_reg == s_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_bank_reg    <= s_bank;
            s1_idx_reg     <= s_idx;
            s1_inrange_reg <= s_inrange;
            s1_raw_reg     <= s_raw_word[BITS_PER_BANK-1:0];
            s1_now_reg     <= s_now_ms;
        end
    end

    // stamp memories: one row per bank, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            press_mem[s1_idx_reg]   <= press_wr;
            release_mem[s1_idx_reg] <= release_wr;
        end
        if (s_accept) begin
            if (fwd) begin
                press_rd_reg   <= press_wr;
                release_rd_reg <= release_wr;
            end else if (row_valid_reg[s_idx]) begin
                press_rd_reg   <= press_mem[s_idx];
                release_rd_reg <= release_mem[s_idx];
            end else begin
                press_rd_reg   <= '0;
                release_rd_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BANKS; k++) begin
                row_valid_reg[k]   <= 1'b0;
                prev_raw_reg[k]    <= '0;
                clean_store_reg[k] <= '0;
            end
        end else if (state_we) begin
            if (enable_reg) begin
                row_valid_reg[s1_idx_reg]   <= 1'b1;
                prev_raw_reg[s1_idx_reg]    <= s1_raw_reg;
                clean_store_reg[s1_idx_reg] <= clean_new;
            end else begin
                clean_store_reg[s1_idx_reg] <= s1_raw_reg;
            end
        end
    end

    // per-bit update, all lanes in parallel
    assign prev_word = prev_raw_reg[s1_idx_reg];
    assign clean_old = clean_store_reg[s1_idx_reg];

    always_comb begin
        press_wr   = press_rd_reg;
        release_wr = release_rd_reg;
        clean_new  = clean_old;
        for (int i = 0; i < BITS_PER_BANK; i++) begin
            press_diff[i]   = s1_now_reg - press_rd_reg[i];
            release_diff[i] = s1_now_reg - release_rd_reg[i];
            if (s1_raw_reg[i] != prev_word[i]) begin
                // level changed: restart the hold timer, leave the clean bit
                if (s1_raw_reg[i]) begin
                    press_wr[i] = s1_now_reg;
                end else begin
                    release_wr[i] = s1_now_reg;
                end
            end else if (s1_raw_reg[i]) begin
                if (press_diff[i] >= SW'(press_time_reg)) begin
                    clean_new[i] = 1'b1;
                end
            end else begin
                if (release_diff[i] >= SW'(release_time_reg)) begin
                    clean_new[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (!s1_inrange_reg) begin
            result_word = '0;
        end else if (!enable_reg) begin
            result_word = abd_pkg::WORD_W'(s1_raw_reg);
        end else begin
            result_word = abd_pkg::WORD_W'(clean_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_bank_reg <= s1_bank_reg;
            m_word_reg <= result_word;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_bank   = m_bank_reg;
    assign m_clean_word = m_word_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (32'(m_out_bank) >= 32'(BANKS))) |-> (m_clean_word == '0))
        else $error("out-of-range bank returned a nonzero word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((64'(m_clean_word) >> BITS_PER_BANK) == 64'd0))
        else $error("clean word has bits above the lane count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("committed request did not reach the result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_bank_reg)))
        else $error("stalled request lost from stage one");
`endif

endmodule

// ----- dv/debounce_checker.sv -----
`timescale 1ns / 1ps

module debounce_checker #(
    parameter int BANKS         = 5,
    parameter int BITS_PER_BANK = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [abd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abd_pkg::HOLD_W-1:0]    cfg_data,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [abd_pkg::BANK_W-1:0]    s_bank,
    input  logic [abd_pkg::WORD_W-1:0]    s_raw_word,
    input  logic [abd_pkg::STAMP_W-1:0]   s_now_ms,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [abd_pkg::BANK_W-1:0]    m_out_bank,
    input  logic [abd_pkg::WORD_W-1:0]    m_clean_word,

    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic [abd_pkg::BANK_W-1:0] bank;
        logic [abd_pkg::WORD_W-1:0] word;
    } clean_result_t;

    localparam logic [abd_pkg::WORD_W-1:0] LANES =
        {abd_pkg::WORD_W{1'b1}} >> (abd_pkg::WORD_W - BITS_PER_BANK);

    logic [abd_pkg::HOLD_W-1:0]  press_hold;
    logic [abd_pkg::HOLD_W-1:0]  release_hold;
    logic                        debounce_on;

    logic [abd_pkg::WORD_W-1:0]  last_raw [BANKS];
    logic [abd_pkg::WORD_W-1:0]  settled  [BANKS];
    logic [abd_pkg::STAMP_W-1:0] press_at   [BANKS][BITS_PER_BANK];
    logic [abd_pkg::STAMP_W-1:0] release_at [BANKS][BITS_PER_BANK];

    clean_result_t      clean_pending [$];
    int                 fail_tally = 0;

    function automatic logic [abd_pkg::WORD_W-1:0] debounce_bank(
        input logic [abd_pkg::BANK_W-1:0]  b,
        input logic [abd_pkg::WORD_W-1:0]  raw_in,
        input logic [abd_pkg::STAMP_W-1:0] now);
        logic [abd_pkg::WORD_W-1:0]  raw;
        logic [abd_pkg::WORD_W-1:0]  word;
        logic [abd_pkg::STAMP_W-1:0] held;
        int                          i;
        raw = raw_in & LANES;
        if (b >= BANKS)
            return '0;
        if (!debounce_on) begin
            // pass through; leave previous word and stamps alone
            settled[b] = raw;
            return raw;
        end
        word = settled[b];
        for (i = 0; i < BITS_PER_BANK; i++) begin
            if (raw[i] != last_raw[b][i]) begin
                if (raw[i])
                    press_at[b][i] = now;
                else
                    release_at[b][i] = now;
            end else if (raw[i]) begin
                held = now - press_at[b][i];
                if (held >= abd_pkg::STAMP_W'(press_hold))
                    word[i] = 1'b1;
            end else begin
                held = now - release_at[b][i];
                if (held >= abd_pkg::STAMP_W'(release_hold))
                    word[i] = 1'b0;
            end
        end
        word        = word & LANES;
        settled[b]  = word;
        last_raw[b] = raw;
        return word;
    endfunction

    always @(posedge aclk) begin
        clean_result_t want;
        int            k;
        int            j;
        if (!aresetn) begin
            press_hold   = abd_pkg::PRESS_TIME_RST;
            release_hold = abd_pkg::RELEASE_TIME_RST;
            debounce_on  = abd_pkg::ENABLE_RST;
            for (k = 0; k < BANKS; k++) begin
                last_raw[k] = '0;
                settled[k]  = '0;
                for (j = 0; j < BITS_PER_BANK; j++) begin
                    press_at[k][j]   = '0;
                    release_at[k][j] = '0;
                end
            end
            clean_pending.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    abd_pkg::CFG_PRESS_TIME:      press_hold   = cfg_data;
                    abd_pkg::CFG_RELEASE_TIME:    release_hold = cfg_data;
                    abd_pkg::CFG_DEBOUNCE_ENABLE: debounce_on  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want.bank = s_bank;
                want.word = debounce_bank(s_bank, s_raw_word, s_now_ms);
                clean_pending.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (clean_pending.size() == 0) begin
                    $error("result for bank %0d with no request pending", m_out_bank);
                    fail_tally++;
                end else begin
                    want = clean_pending.pop_front();
                    if (m_out_bank !== want.bank) begin
                        $error("out_bank: expected %0d, got %0d", want.bank, m_out_bank);
                        fail_tally++;
                    end
                    if (m_clean_word !== want.word) begin
                        $error("clean_word: expected %08h, got %08h", want.word, m_clean_word);
                        fail_tally++;
                    end
                end
            end
        end
        mismatches  <= fail_tally;
        outstanding <= clean_pending.size();
    end

endmodule

// ----- dv/tb_asymmetric_bit_debouncer_core.sv -----
`timescale 1ns / 1ps

module tb_asymmetric_bit_debouncer_core;

    localparam int                BANKS          = 5;
    localparam int                BITS_PER_BANK  = 32;
    localparam int                PHASES         = 7;
    localparam int                PHASE_REQS     = 220;
    localparam abd_pkg::cfg_idx_t CFG_UNUSED     = 2'd3;

    logic                          aclk;
    logic                          aresetn;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [abd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [abd_pkg::HOLD_W-1:0]    cfg_data;

    logic                          s_valid;
    logic                          s_ready;
    logic [abd_pkg::BANK_W-1:0]    s_bank;
    logic [abd_pkg::WORD_W-1:0]    s_raw_word;
    logic [abd_pkg::STAMP_W-1:0]   s_now_ms;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [abd_pkg::BANK_W-1:0]    m_out_bank;
    logic [abd_pkg::WORD_W-1:0]    m_clean_word;

    int                            fail_count;
    int                            pending;

    bit                            gaps_on = 1'b1;
    logic [abd_pkg::WORD_W-1:0]    bank_levels [8];
    logic [abd_pkg::STAMP_W-1:0]   clock_ms;

    asymmetric_bit_debouncer_core #(
        .BANKS         (BANKS),
        .BITS_PER_BANK (BITS_PER_BANK)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_bank       (s_bank),
        .s_raw_word   (s_raw_word),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_bank   (m_out_bank),
        .m_clean_word (m_clean_word)
    );

    debounce_checker #(
        .BANKS         (BANKS),
        .BITS_PER_BANK (BITS_PER_BANK)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_bank       (s_bank),
        .s_raw_word   (s_raw_word),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_bank   (m_out_bank),
        .m_clean_word (m_clean_word),
        .mismatches   (fail_count),
        .outstanding  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_asymmetric_bit_debouncer_core NOT OK");
        $finish;
    end

    // mostly short, now and then long
    function automatic int stall_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 1) == 0)
            return 0;
        return stall_len();
    endfunction

    // result-side backpressure, with calm stretches
    int sink_hold = 0;
    int sink_span = 0;
    bit sink_calm = 1'b0;

    always @(posedge aclk) begin
        if (sink_span == 0) begin
            sink_calm = ($urandom_range(0, 3) == 0);
            sink_span = $urandom_range(40, 300);
        end else begin
            sink_span = sink_span - 1;
        end
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_ready <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            sink_hold = stall_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_req(input logic [abd_pkg::BANK_W-1:0]  b,
                            input logic [abd_pkg::WORD_W-1:0]  raw,
                            input logic [abd_pkg::STAMP_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_bank     <= b;
        s_raw_word <= raw;
        s_now_ms   <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every request has its result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input abd_pkg::cfg_idx_t idx,
                             input logic [abd_pkg::HOLD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_req(input int tick_max);
        logic [abd_pkg::BANK_W-1:0] b;
        logic [abd_pkg::WORD_W-1:0] flips;
        int                         r;
        if ($urandom_range(0, 99) < 6)
            b = abd_pkg::BANK_W'($urandom_range(BANKS, 7));
        else
            b = abd_pkg::BANK_W'($urandom_range(0, BANKS - 1));
        // flip few lanes so most stay steady long enough to settle
        r = $urandom_range(0, 99);
        if (r < 40)
            flips = '0;
        else if (r < 85)
            flips = abd_pkg::WORD_W'(1) << $urandom_range(0, abd_pkg::WORD_W - 1);
        else if (r < 95)
            flips = $urandom() & $urandom() & $urandom();
        else
            flips = $urandom();
        bank_levels[b] = bank_levels[b] ^ flips;
        r = $urandom_range(0, 99);
        if (r < 2)
            clock_ms = $urandom();
        else if (r < 10)
            clock_ms = clock_ms + $urandom_range(0, 140000);
        else
            clock_ms = clock_ms + $urandom_range(0, tick_max);
        send_req(b, bank_levels[b], clock_ms);
    endtask

    initial begin
        int p;
        int n;
        int tick_max;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = abd_pkg::CFG_PRESS_TIME;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_bank     = '0;
        s_raw_word = '0;
        s_now_ms   = '0;
        clock_ms   = '0;
        for (n = 0; n < 8; n++)
            bank_levels[n] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset hold times: 10 ms each way
        send_req(3'd0, 32'h0000_0000, 32'd0);
        send_req(3'd0, 32'hFFFF_FFFF, 32'd100);
        send_req(3'd0, 32'hFFFF_FFFF, 32'd109);
        send_req(3'd0, 32'hFFFF_FFFF, 32'd110);
        send_req(3'd0, 32'h0000_0000, 32'd200);
        send_req(3'd0, 32'h0000_0000, 32'd210);
        // press held across the wrap of the millisecond counter
        send_req(3'd4, 32'hAAAA_AAAA, 32'hFFFF_FFF8);
        send_req(3'd4, 32'hAAAA_AAAA, 32'h0000_0002);
        send_req(3'd5, 32'hFFFF_FFFF, 32'd300);
        send_req(3'd7, 32'h5555_5555, 32'hFFFF_FFFF);
        send_req(3'd6, 32'h0000_0000, 32'd0);
        send_req(3'd1, 32'h5555_5555, 32'd300);
        send_req(3'd1, 32'h5555_5555, 32'd305);
        send_req(3'd1, 32'hAAAA_AAAA, 32'd320);
        send_req(3'd2, 32'h8000_0001, 32'h1234_5678);
        send_req(3'd3, 32'h7FFF_FFFE, 32'h8765_4321);
        drain_results();

        // zero hold time settles on the first steady step after a change
        write_reg(abd_pkg::CFG_PRESS_TIME, 16'd0);
        write_reg(abd_pkg::CFG_RELEASE_TIME, 16'd0);
        send_req(3'd2, 32'h8000_0001, 32'h1234_5678);
        send_req(3'd3, 32'h0000_0000, 32'd0);
        send_req(3'd3, 32'h0000_0000, 32'd0);
        drain_results();

        // only bit 0 of the enable register counts
        write_reg(abd_pkg::CFG_DEBOUNCE_ENABLE, 16'hFFFE);
        send_req(3'd1, 32'h1234_5678, 32'd0);
        send_req(3'd7, 32'hFFFF_FFFF, 32'd5);
        drain_results();
        write_reg(abd_pkg::CFG_DEBOUNCE_ENABLE, 16'h0001);
        write_reg(CFG_UNUSED, 16'h5A5A);
        send_req(3'd1, 32'h1234_5678, 32'd1);
        clock_ms = 32'd1000;
        drain_results();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(abd_pkg::CFG_PRESS_TIME, abd_pkg::PRESS_TIME_RST);
                    write_reg(abd_pkg::CFG_RELEASE_TIME, abd_pkg::RELEASE_TIME_RST);
                    tick_max = 4;
                end
                1: begin
                    write_reg(abd_pkg::CFG_PRESS_TIME, 16'd0);
                    write_reg(abd_pkg::CFG_RELEASE_TIME, 16'd0);
                    tick_max = 3;
                end
                2: begin
                    write_reg(abd_pkg::CFG_PRESS_TIME, 16'hFFFF);
                    write_reg(abd_pkg::CFG_RELEASE_TIME, 16'hFFFF);
                    tick_max = 30000;
                end
                3: begin
                    write_reg(abd_pkg::CFG_PRESS_TIME, 16'($urandom_range(1, 40)));
                    write_reg(abd_pkg::CFG_RELEASE_TIME, 16'($urandom_range(1, 40)));
                    clock_ms = 32'hFFFF_F000;
                    tick_max = 12;
                end
                4: begin
                    write_reg(abd_pkg::CFG_DEBOUNCE_ENABLE, 16'h0000);
                    tick_max = 5;
                end
                5: begin
                    write_reg(abd_pkg::CFG_DEBOUNCE_ENABLE, 16'h0001);
                    write_reg(abd_pkg::CFG_PRESS_TIME, 16'd3);
                    write_reg(abd_pkg::CFG_RELEASE_TIME, 16'd60);
                    write_reg(CFG_UNUSED, 16'($urandom()));
                    tick_max = 8;
                end
                default: begin
                    write_reg(abd_pkg::CFG_PRESS_TIME, 16'($urandom()));
                    write_reg(abd_pkg::CFG_RELEASE_TIME, 16'($urandom()));
                    tick_max = 20000;
                end
            endcase
            for (n = 0; n < PHASE_REQS; n++) begin
                if (n % 50 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                if (n == PHASE_REQS / 2 && p == 2)
                    drain_results();
                random_req(tick_max);
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_asymmetric_bit_debouncer_core OK");
        end else begin
            $display("tb_asymmetric_bit_debouncer_core NOT OK");
        end
        $finish;
    end

endmodule
